// File: rtl/stig_pkg.sv
// Package for the UV-sphere triangle index generator.
// Request/result beat types, part codes, register indexes and range limits.
package stig_pkg;

    localparam int CFG_W  = 9;   // width of each configuration register
    localparam int IDX_W  = 17;  // width of every index field
    localparam int CIDX_W = 2;   // configuration register index width

    localparam int DEF_MAX_RINGS    = 256;
    localparam int DEF_MAX_SEGMENTS = 256;

    localparam logic [CFG_W-1:0] RING_LO  = CFG_W'(1);
    localparam logic [CFG_W-1:0] SEG_LO   = CFG_W'(3);
    localparam logic [CFG_W-1:0] RING_RST = CFG_W'(1);
    localparam logic [CFG_W-1:0] SEG_RST  = CFG_W'(3);

    localparam logic [CIDX_W-1:0] REG_RING_COUNT    = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_SEGMENT_COUNT = CIDX_W'(1);

    localparam logic [1:0] PART_UPPER = 2'd0;
    localparam logic [1:0] PART_LOWER = 2'd1;
    localparam logic [1:0] PART_SOUTH = 2'd2;
    localparam logic [1:0] PART_NORTH = 2'd3;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] column;
        logic [1:0] part;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] vert_a;
        logic [IDX_W-1:0] vert_b;
        logic [IDX_W-1:0] vert_c;
        logic [IDX_W-1:0] norm_a;
        logic [IDX_W-1:0] norm_b;
        logic [IDX_W-1:0] norm_c;
        logic [IDX_W-1:0] tex_a;
        logic [IDX_W-1:0] tex_b;
        logic [IDX_W-1:0] tex_c;
        logic             rejected;
    } t_res;

    // Mesh constants derived from the configuration, held in registers.
    typedef struct packed {
        logic [CFG_W-1:0] ring;      // R
        logic [CFG_W-1:0] seg;       // S
        logic [IDX_W-1:0] rs;        // R*S
        logic [IDX_W-1:0] rs_m_s;    // (R-1)*S: vertex base of the top ring
        logic [IDX_W-1:0] rs2_m_s;   // 2*R*S - S: first north fan slot
        logic [IDX_W-1:0] rs_p_r;    // R*(S+1): first pole texture index
        logic [IDX_W-1:0] tex_top;   // (R-1)*(S+1): texture base of the top ring
    } t_mesh;

endpackage

// File: rtl/stig_calc.sv
// Index arithmetic for one triangle request (combinational).
// Depends on stig_pkg for the beat types and mesh constants.
module stig_calc (
    input  stig_pkg::t_req  i_req,
    input  stig_pkg::t_mesh i_mesh,
    output stig_pkg::t_res  o_res
);
    import stig_pkg::*;

    logic [IDX_W-1:0] seg;
    logic [IDX_W-1:0] seg_p1;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] col_p1;
    logic [IDX_W-1:0] col_wrap;
    logic [IDX_W-1:0] cell_base;
    logic [IDX_W-1:0] cell_tex;
    logic [CFG_W-1:0] row_p1;
    logic             is_cell;
    logic             bad;
    t_res             res;

    assign seg      = IDX_W'(i_mesh.seg);
    assign seg_p1   = seg + IDX_W'(1);
    assign row      = IDX_W'(i_req.row);
    assign col      = IDX_W'(i_req.column);
    assign col_p1   = col + IDX_W'(1);
    // next column around the ring, wrapping at the seam for vertices/normals
    assign col_wrap = (col_p1 == seg) ? '0 : col_p1;

    assign cell_base = row * seg;
    assign cell_tex  = cell_base + row;   // row*(S+1)

    assign row_p1  = CFG_W'(i_req.row) + CFG_W'(1);
    assign is_cell = (i_req.part == PART_UPPER) || (i_req.part == PART_LOWER);
    assign bad     = (CFG_W'(i_req.column) >= i_mesh.seg) ||
                     (is_cell && (row_p1 >= i_mesh.ring));

    always_comb begin
        res = '0;
        unique case (i_req.part)
            PART_UPPER: begin
                res.slot   = cell_base + col;
                res.vert_a = cell_base + col;
                res.vert_b = cell_base + col_wrap;
                res.vert_c = cell_base + seg + col_wrap;
                res.norm_a = res.vert_a;
                res.norm_b = res.vert_b;
                res.norm_c = res.vert_c;
                res.tex_a  = cell_tex + col;
                res.tex_b  = cell_tex + col_p1;
                res.tex_c  = cell_tex + seg_p1 + col_p1;
            end
            PART_LOWER: begin
                res.slot   = i_mesh.rs + cell_base + col;
                res.vert_a = cell_base + col;
                res.vert_b = cell_base + seg + col_wrap;
                res.vert_c = cell_base + seg + col;
                res.norm_a = res.vert_a;
                res.norm_b = res.vert_b;
                res.norm_c = res.vert_c;
                res.tex_a  = cell_tex + col;
                res.tex_b  = cell_tex + seg_p1 + col_p1;
                res.tex_c  = cell_tex + seg_p1 + col;
            end
            PART_SOUTH: begin
                res.slot   = i_mesh.rs_m_s + col;
                res.vert_a = i_mesh.rs;
                res.vert_b = col_wrap;
                res.vert_c = col;
                res.norm_a = i_mesh.rs + col;
                res.norm_b = col_wrap;
                res.norm_c = col;
                res.tex_a  = i_mesh.rs_p_r + col;
                res.tex_b  = col_p1;
                res.tex_c  = col;
            end
            PART_NORTH: begin
                res.slot   = i_mesh.rs2_m_s + col;
                res.vert_a = i_mesh.rs + IDX_W'(1);
                res.vert_b = i_mesh.rs_m_s + col;
                res.vert_c = i_mesh.rs_m_s + col_wrap;
                res.norm_a = i_mesh.rs + seg + col;
                res.norm_b = res.vert_b;
                res.norm_c = res.vert_c;
                res.tex_a  = i_mesh.rs_p_r + seg + col;
                res.tex_b  = i_mesh.tex_top + col;
                res.tex_c  = i_mesh.tex_top + col_p1;
            end
            default: res = '0;
        endcase
        if (bad) begin
            res          = '0;
            res.rejected = 1'b1;
        end
    end

    assign o_res = res;

endmodule

// File: rtl/sphere_triangle_index_gen.sv
// UV-sphere triangle index generator, top level.
// Depends on stig_pkg and stig_calc.
//
// Usage: a request beat (row, column, part) enters on the input channel and
// one result beat (buffer slot, three vertex, normal and texture indices,
// reject flag) leaves on the output channel, in request order. A beat moves
// when its valid is high and its stall is low.
// Path: an accepted request is held in the input register, then the index
// arithmetic result is captured in the result register, which drives the
// output channel.
// Throughput: one beat per cycle unless the receiver stalls; the input and
// result registers form a two-stage pipeline, so a new request is taken while
// a finished result still waits. The row*segment multiply is the longest path.
// Receiver stall: the result register holds; the input register holds behind
// it and the input channel stalls only once both are full.
// Configuration: ring_count (index 0) and segment_count (index 1) are written
// through the plain write port while the block is idle: a rule for the user,
// not enforced by the block. Out-of-range values saturate, other indexes are
// ignored. The derived mesh constants are registered the cycle after a write.
// Reset (synchronous, active low): pipeline empty, ring_count 1,
// segment_count 3.
module sphere_triangle_index_gen #(
    parameter int MAX_RINGS    = stig_pkg::DEF_MAX_RINGS,
    parameter int MAX_SEGMENTS = stig_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stig_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [stig_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  stig_pkg::t_req                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output stig_pkg::t_res                   o_out_data
);
    import stig_pkg::*;

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam logic [CFG_W-1:0] RING_HI =
        CFG_W'((MAX_RINGS > CFG_MAX) ? CFG_MAX : MAX_RINGS);
    localparam logic [CFG_W-1:0] SEG_HI =
        CFG_W'((MAX_SEGMENTS > CFG_MAX) ? CFG_MAX : MAX_SEGMENTS);

    logic [CFG_W-1:0]   r_ring;
    logic [CFG_W-1:0]   r_seg;
    logic [CFG_W-1:0]   n_ring;
    logic [CFG_W-1:0]   n_seg;
    t_mesh              r_mesh;
    t_mesh              n_mesh;
    logic [2*CFG_W-1:0] prod_rs;

    logic               r_s1_valid;
    t_req               r_s1_req;
    logic               r_out_valid;
    t_res               r_out_data;
    t_res               calc_res;
    logic               out_take;
    logic               s1_load;

    // ---------------- configuration ----------------
    always_comb begin
        n_ring = r_ring;
        n_seg  = r_seg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RING_COUNT: begin
                    if (i_cfg_data < RING_LO)      n_ring = RING_LO;
                    else if (i_cfg_data > RING_HI) n_ring = RING_HI;
                    else                           n_ring = i_cfg_data;
                end
                REG_SEGMENT_COUNT: begin
                    if (i_cfg_data < SEG_LO)       n_seg = SEG_LO;
                    else if (i_cfg_data > SEG_HI)  n_seg = SEG_HI;
                    else                           n_seg = i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= RING_RST;
            r_seg  <= SEG_RST;
        end else begin
            r_ring <= n_ring;
            r_seg  <= n_seg;
        end
    end

    // Mesh constants, all modulo 2^17 like the output fields.
    assign prod_rs = (2*CFG_W)'(r_ring) * (2*CFG_W)'(r_seg);
    always_comb begin
        n_mesh.ring    = r_ring;
        n_mesh.seg     = r_seg;
        n_mesh.rs      = prod_rs[IDX_W-1:0];
        n_mesh.rs_m_s  = prod_rs[IDX_W-1:0] - IDX_W'(r_seg);
        n_mesh.rs2_m_s = {prod_rs[IDX_W-2:0], 1'b0} - IDX_W'(r_seg);
        n_mesh.rs_p_r  = prod_rs[IDX_W-1:0] + IDX_W'(r_ring);
        n_mesh.tex_top = prod_rs[IDX_W-1:0] + IDX_W'(r_ring) - IDX_W'(r_seg)
                         - IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        r_mesh <= n_mesh;
    end

    // ---------------- pipeline ----------------
    assign out_take   = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || out_take;
    assign o_in_stall = !s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load)  r_s1_valid  <= i_in_valid;
            if (out_take) r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) r_s1_req   <= i_in_data;
        if (out_take && r_s1_valid) r_out_data <= calc_res;
    end

    stig_calc u_calc (
        .i_req  (r_s1_req),
        .i_mesh (r_mesh),
        .o_res  (calc_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- checks ----------------
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.rejected) |->
            (r_out_data.slot == '0 && r_out_data.vert_a == '0 &&
             r_out_data.tex_c == '0))
        else $error("rejected result carries nonzero indices");

    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring >= RING_LO && r_ring <= RING_HI &&
         r_seg >= SEG_LO && r_seg <= SEG_HI))
        else $error("configuration register outside its range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_take) |=> r_out_valid)
        else $error("request in flight lost on the way to the result register");

endmodule

// File: tb/sv/sphere_triangle_index_gen_tb.sv
// Self-checking testbench for sphere_triangle_index_gen: a queue-fed driver, a
// monitor that checks every result beat against an in-bench index calculator.
// Depends on stig_pkg and the sphere_triangle_index_gen RTL.
`timescale 1ns / 100ps

module sphere_triangle_index_gen_tb;
    import stig_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    // Register indexes the block does not decode.
    localparam logic [CIDX_W-1:0] REG_UNUSED_2 = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_UNUSED_3 = CIDX_W'(3);

    // Idle patterns for the two channels.
    localparam int MODE_NONE   = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_RECV   = 2;
    localparam int MODE_BOTH   = 3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    t_req              in_data   = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    t_res              out_data;

    t_req        pending_q[$];
    t_res        tri_exp_q[$];
    int unsigned ring_cur = 32'(RING_RST);
    int unsigned seg_cur  = 32'(SEG_RST);
    int          idle_mode = MODE_NONE;
    int          hold_trig = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_rejected = 0;
    int          n_err = 0;

    sphere_triangle_index_gen dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------- predictor
    function automatic int unsigned vtx_at(int unsigned r, int unsigned c, int unsigned s);
        return r * s + (c % s);
    endfunction

    function automatic int unsigned uv_at(int unsigned r, int unsigned c, int unsigned s);
        return r * (s + 1) + c;
    endfunction

    function automatic t_res tri_indices(t_req rq, int unsigned rc, int unsigned sc);
        t_res        o;
        int unsigned r;
        int unsigned c;
        logic        is_cell;
        o       = '0;
        r       = 32'(rq.row);
        c       = 32'(rq.column);
        is_cell = (rq.part == PART_UPPER) || (rq.part == PART_LOWER);
        if (c >= sc || (is_cell && r + 1 >= rc)) begin
            o.rejected = 1'b1;
        end else begin
            case (rq.part)
                PART_UPPER: begin
                    o.slot   = IDX_W'(r * sc + c);
                    o.vert_a = IDX_W'(vtx_at(r, c, sc));
                    o.vert_b = IDX_W'(vtx_at(r, c + 1, sc));
                    o.vert_c = IDX_W'(vtx_at(r + 1, c + 1, sc));
                    o.tex_a  = IDX_W'(uv_at(r, c, sc));
                    o.tex_b  = IDX_W'(uv_at(r, c + 1, sc));
                    o.tex_c  = IDX_W'(uv_at(r + 1, c + 1, sc));
                    o.norm_a = o.vert_a;
                end
                PART_LOWER: begin
                    o.slot   = IDX_W'(rc * sc + r * sc + c);
                    o.vert_a = IDX_W'(vtx_at(r, c, sc));
                    o.vert_b = IDX_W'(vtx_at(r + 1, c + 1, sc));
                    o.vert_c = IDX_W'(vtx_at(r + 1, c, sc));
                    o.tex_a  = IDX_W'(uv_at(r, c, sc));
                    o.tex_b  = IDX_W'(uv_at(r + 1, c + 1, sc));
                    o.tex_c  = IDX_W'(uv_at(r + 1, c, sc));
                    o.norm_a = o.vert_a;
                end
                PART_SOUTH: begin
                    o.slot   = IDX_W'((rc - 1) * sc + c);
                    o.vert_a = IDX_W'(rc * sc);
                    o.vert_b = IDX_W'(vtx_at(0, c + 1, sc));
                    o.vert_c = IDX_W'(vtx_at(0, c, sc));
                    o.norm_a = IDX_W'(rc * sc + c);
                    o.tex_a  = IDX_W'(rc * (sc + 1) + c);
                    o.tex_b  = IDX_W'(uv_at(0, c + 1, sc));
                    o.tex_c  = IDX_W'(uv_at(0, c, sc));
                end
                default: begin
                    o.slot   = IDX_W'((rc - 1) * sc + rc * sc + c);
                    o.vert_a = IDX_W'(rc * sc + 1);
                    o.vert_b = IDX_W'(vtx_at(rc - 1, c, sc));
                    o.vert_c = IDX_W'(vtx_at(rc - 1, c + 1, sc));
                    o.norm_a = IDX_W'(rc * sc + sc + c);
                    o.tex_a  = IDX_W'(rc * (sc + 1) + sc + c);
                    o.tex_b  = IDX_W'(uv_at(rc - 1, c, sc));
                    o.tex_c  = IDX_W'(uv_at(rc - 1, c + 1, sc));
                end
            endcase
            // corners b and c always share the vertex index for normals
            o.norm_b = o.vert_b;
            o.norm_c = o.vert_c;
        end
        return o;
    endfunction

    function automatic string fmt_res(t_res r);
        return $sformatf("slot=%0d v=%0d/%0d/%0d n=%0d/%0d/%0d t=%0d/%0d/%0d rej=%0b",
                         r.slot, r.vert_a, r.vert_b, r.vert_c, r.norm_a, r.norm_b,
                         r.norm_c, r.tex_a, r.tex_b, r.tex_c, r.rejected);
    endfunction

    function automatic int sender_idle_pct();
        return (idle_mode == MODE_SENDER) ? 60 : (idle_mode == MODE_BOTH) ? 19 : 0;
    endfunction

    function automatic int recv_stall_pct();
        return (idle_mode == MODE_RECV) ? 60 : (idle_mode == MODE_BOTH) ? 19 : 0;
    endfunction

    // ---------------------------------------------------------------- driver
    always @(posedge clk) begin : drv
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                tri_exp_q.push_back(tri_indices(in_data, ring_cur, seg_cur));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    in_data  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver stall
    always @(posedge clk) begin : rcv
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge clk) begin : mon
        t_res want;
        if (rst_n && out_valid && !out_stall) begin
            if (tri_exp_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result beat: %s", fmt_res(out_data));
            end else begin
                want = tri_exp_q.pop_front();
                n_checked++;
                if (want.rejected) n_rejected++;
                if (out_data.slot !== want.slot ||
                    out_data.vert_a !== want.vert_a || out_data.vert_b !== want.vert_b ||
                    out_data.vert_c !== want.vert_c || out_data.norm_a !== want.norm_a ||
                    out_data.norm_b !== want.norm_b || out_data.norm_c !== want.norm_c ||
                    out_data.tex_a !== want.tex_a || out_data.tex_b !== want.tex_b ||
                    out_data.tex_c !== want.tex_c || out_data.rejected !== want.rejected) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch on beat %0d (R=%0d S=%0d)", n_checked, ring_cur, seg_cur);
                        $display("  exp %s", fmt_res(want));
                        $display("  got %s", fmt_res(out_data));
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_req(input int unsigned row, input int unsigned col,
                           input logic [1:0] part);
        t_req rq;
        rq.row    = row[7:0];
        rq.column = col[7:0];
        rq.part   = part;
        pending_q.push_back(rq);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || tri_exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        int unsigned v;
        v = 32'(val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_RING_COUNT)
            ring_cur = (v < 32'(RING_LO)) ? 32'(RING_LO) :
                       (v > DEF_MAX_RINGS) ? DEF_MAX_RINGS : v;
        else if (idx == REG_SEGMENT_COUNT)
            seg_cur = (v < 32'(SEG_LO)) ? 32'(SEG_LO) :
                      (v > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : v;
    endtask

    task automatic set_mesh(input logic [CFG_W-1:0] ring_val, input logic [CFG_W-1:0] seg_val);
        wait_idle();
        write_reg(REG_RING_COUNT, ring_val);
        write_reg(REG_SEGMENT_COUNT, seg_val);
        write_reg(REG_UNUSED_2, CFG_W'($urandom));
        write_reg(REG_UNUSED_3, CFG_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        // derived mesh constants are registered the cycle after the write
        repeat (4) @(posedge clk);
    endtask

    task automatic add_random(input int n);
        int unsigned row;
        int unsigned col;
        int unsigned part;
        for (int i = 0; i < n; i++) begin
            part = $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 80) begin
                col = ($urandom_range(0, 7) == 0) ? seg_cur - 1 : $urandom_range(0, seg_cur - 1);
                if (part < 2 && ring_cur >= 2)
                    row = ($urandom_range(0, 7) == 0) ? ring_cur - 2
                                                      : $urandom_range(0, ring_cur - 2);
                else
                    row = $urandom_range(0, 255);
            end else begin
                row = $urandom_range(0, 255);
                col = $urandom_range(0, 255);
            end
            add_req(row, col, part[1:0]);
        end
    endtask

    initial begin : stim
        logic [CFG_W-1:0] rv;
        logic [CFG_W-1:0] sv;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset mesh (one ring, three segments): only pole fans are legal.
        add_req(0, 0, PART_SOUTH);
        add_req(0, 2, PART_SOUTH);
        add_req(255, 0, PART_NORTH);
        add_req(0, 2, PART_NORTH);
        add_req(0, 3, PART_SOUTH);
        add_req(0, 255, PART_NORTH);
        add_req(0, 0, PART_UPPER);
        add_req(255, 255, PART_LOWER);

        // Largest mesh via saturating writes.
        set_mesh(CFG_W'(511), CFG_W'(511));
        add_req(0, 0, PART_UPPER);
        add_req(254, 255, PART_UPPER);
        add_req(0, 0, PART_LOWER);
        add_req(254, 255, PART_LOWER);
        add_req(255, 0, PART_UPPER);
        add_req(255, 128, PART_LOWER);
        add_req(0, 0, PART_SOUTH);
        add_req(255, 255, PART_SOUTH);
        add_req(0, 0, PART_NORTH);
        add_req(0, 255, PART_NORTH);
        add_req(170, 85, PART_NORTH);
        add_req(85, 170, PART_UPPER);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin rv = CFG_W'(300); sv = CFG_W'(256); end
                1: begin rv = CFG_W'(0);   sv = CFG_W'(0);   end
                2: begin rv = CFG_W'(2);   sv = CFG_W'(2);   end
                4: begin rv = CFG_W'(256); sv = CFG_W'(3);   end
                5: begin rv = CFG_W'(3);   sv = CFG_W'(257); end
                7: begin
                    rv = CFG_W'($urandom_range(1, 8));
                    sv = CFG_W'($urandom_range(3, 10));
                end
                default: begin
                    rv = CFG_W'($urandom_range(0, 511));
                    sv = CFG_W'($urandom_range(0, 511));
                end
            endcase
            set_mesh(rv, sv);
            idle_mode = ph % 4;
            if (ph == 0) begin
                // sender keeps offering while the receiver holds off
                add_random(130);
                hold_trig <= hold_trig + 1;
            end else if (ph == 4) begin
                add_random(65);
                wait_idle();
                add_random(65);
            end else begin
                add_random(130);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (tri_exp_q.size() != 0) begin
            n_err++;
            $display("%0d expected result beats never arrived", tri_exp_q.size());
        end
        $display("covered %0d request beats, %0d results checked (%0d rejected), 10 meshes",
                 n_accepted, n_checked, n_rejected);
        $display("including reset and saturated sizes, idle mixes and a long output hold");
        if (n_err == 0) begin
            $display("sphere_triangle_index_gen_tb OK");
        end else begin
            $display("%0d failures", n_err);
            $display("sphere_triangle_index_gen_tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("sphere_triangle_index_gen_tb NOT OK");
        $finish;
    end

endmodule
